FILE: rtl/core/bse_pkg.sv
`default_nettype none

package bse_pkg;

  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t lo;
    word_t hi;
  } pair_t;

endpackage

`default_nettype wire

FILE: rtl/core/bse_ram.sv
`default_nettype none

module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/bse_cmp_swap.sv
`default_nettype none

module bse_cmp_swap (
  input  wire logic          [bse_pkg::WORD_W-1:0] a,
  input  wire logic          [bse_pkg::WORD_W-1:0] b,
  output bse_pkg::pair_t                            pair
);

  logic gt;

  // equal values keep their order
  assign gt      = $signed(a) > $signed(b);
  assign pair.lo = gt ? b : a;
  assign pair.hi = gt ? a : b;

endmodule

`default_nettype wire

FILE: rtl/core/bubble_sort_engine.sv
// sorting: bubble passes over the store run after the final input beat, before the first output beat;
//   each output beat waits for its word to be read from the store
// throughput: one value per cycle while loading, then one set at a time;
//   the single compare-swap unit and one memory read port set the sort time
// reset: element count clears, the block starts empty and ready to load
`default_nettype none

module bubble_sort_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] value,
  input  wire logic        last_in,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic      [31:0] sorted_value,
  output logic             last_out,
  output logic             out_valid,
  input  wire logic        out_stall
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_FIRST = 5'b00010,
    S_CMP   = 5'b00100,
    S_TAIL  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t              state;
  logic                showing;
  logic [CW-1:0]       count;
  logic [AW-1:0]       k;
  logic [AW-1:0]       end_idx;
  bse_pkg::word_t      carry;

  logic                we;
  logic [AW-1:0]       waddr;
  bse_pkg::word_t      wdata;
  logic [AW-1:0]       raddr;
  bse_pkg::word_t      rdata;
  bse_pkg::pair_t      pair;

  logic [CW-1:0]       count_inc;
  logic [CW-1:0]       count_dec;
  logic [AW-1:0]       last_idx;
  logic                in_beat;
  logic                out_beat;
  logic                set_end;

  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign last_idx  = count_dec[AW-1:0];
  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid && !out_stall;
  assign set_end   = last_in || (count_inc == CW'(DEPTH));

  assign in_stall     = (state != S_LOAD);
  assign out_valid    = (state == S_OUT) && showing;
  assign sorted_value = rdata;
  assign last_out     = (k == last_idx);

  bse_ram #(
    .WIDTH(bse_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bse_cmp_swap u_cmp (
    .a   (carry),
    .b   (rdata),
    .pair(pair)
  );

  always_comb begin
    we    = 1'b0;
    waddr = k;
    wdata = pair.lo;
    raddr = '0;
    unique case (state)
      S_LOAD: begin
        we    = in_beat;
        waddr = count[AW-1:0];
        wdata = value;
      end
      S_FIRST: begin
        raddr = k + AW'(1);
      end
      S_CMP: begin
        we    = 1'b1;
        raddr = k + AW'(2);
      end
      S_TAIL: begin
        we    = 1'b1;
        waddr = end_idx;
        wdata = carry;
      end
      S_OUT: begin
        raddr = k;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      showing <= 1'b0;
      k       <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          k       <= '0;
          showing <= 1'b0;
          if (in_beat) begin
            count   <= count_inc;
            end_idx <= count[AW-1:0];
            if (set_end) begin
              state <= (count == '0) ? S_OUT : S_FIRST;
            end
          end
        end
        S_FIRST: begin
          carry <= rdata;
          state <= S_CMP;
        end
        S_CMP: begin
          carry <= pair.hi;
          if (k + AW'(1) == end_idx) begin
            state <= S_TAIL;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_TAIL: begin
          k <= '0;
          if (end_idx == AW'(1)) begin
            state <= S_OUT;
          end else begin
            end_idx <= end_idx - AW'(1);
            state   <= S_FIRST;
          end
        end
        S_OUT: begin
          // read data is valid in the cycle after the address settles
          if (!showing) begin
            showing <= 1'b1;
          end else if (out_beat) begin
            showing <= 1'b0;
            if (last_out) begin
              count <= '0;
              k     <= '0;
              state <= S_LOAD;
            end else begin
              k <= k + AW'(1);
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> count < CW'(DEPTH))
    else $error("ready with a full store");

  a_end_starts: assert property (@(posedge clk) disable iff (rst)
    (in_beat && last_in) |=> (state == S_FIRST || state == S_OUT))
    else $error("final beat did not start the sort");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> k < end_idx)
    else $error("compare index past pass end");

  a_set_done: assert property (@(posedge clk) disable iff (rst)
    (out_beat && last_out) |=> (count == '0 && !in_stall))
    else $error("store not emptied after last beat");

endmodule

`default_nettype wire
